FILE: design/sar_pkg.sv
package sar_pkg;

   // Fixed field widths of the request and response
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;

   // Live map row geometry
   localparam int ROW_BITS = 5;
   localparam int ROW_W    = 32;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_LIVE = 2'd2
   } sar_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POP,
      ST_ALLOC_WR,
      ST_REL_CHK,
      ST_SCAN,
      ST_SCAN_END,
      ST_RESP
   } sar_state_type;

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] slot_id;
   } sar_req_type;

   typedef struct packed {
      sar_status_type     status;
      logic [SLOT_W-1:0]  granted_slot;
      logic [COUNT_W-1:0] live_count;
      logic [SLOT_W-1:0]  first_live;
      logic [SLOT_W-1:0]  last_live;
   } sar_rsp_type;

   function automatic logic [ROW_BITS-1:0] lowest_set(input logic [ROW_W-1:0] word);
      logic [ROW_BITS-1:0] pos;
      pos = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = ROW_BITS'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [ROW_BITS-1:0] highest_set(input logic [ROW_W-1:0] word);
      logic [ROW_BITS-1:0] pos;
      pos = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (word[i]) begin
            pos = ROW_BITS'(i);
         end
      end
      return pos;
   endfunction

endpackage

FILE: design/sar_ram.sv
module sar_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/slot_allocator_active_range_core.sv
// Slot allocator with a last-in-first-out free stack and live range tracking.
// Requests: start with req_data (cmd, slot_id) is taken at a clock edge where
// busy is low. Allocate pops the most recently freed slot, or hands out the
// next fresh index when the stack is empty; it answers full at the limit.
// Release clears the slot's live bit and pushes it onto the stack.
// Each request gives one response, shown on rsp_data for a single cycle with
// rsp_valid high; the receiver cannot stall it. A new request may be taken in
// the cycle that shows the previous response.
// Accept to response: full allocate straight to ST_RESP; fresh allocate via
// ST_ALLOC_WR; from the stack via ST_POP, ST_ALLOC_WR; release via ST_REL_CHK.
// Releasing the lowest or highest live slot rescans the live map one 32-bit
// row per cycle, ROWS = ceil(SLOT_CAPACITY / 32) rows, in ST_SCAN then
// ST_SCAN_END. Timing follows the registered read of the live map and free
// stack memories (read, modify, write back). After reset a clearing pass
// zeroes the live map, one row per cycle, with busy high; csr writes are taken
// during it. The free stack is not cleared: only pushed entries are read.
// csr_wr_data sets slot_limit (reset 1024); write it only while idle.
module slot_allocator_active_range_core #(
   parameter int SLOT_CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sar_pkg::sar_req_type        req_data,
   output logic                        rsp_valid,
   output sar_pkg::sar_rsp_type        rsp_data,
   input  logic                        csr_wr_en,
   input  logic [sar_pkg::COUNT_W-1:0] csr_wr_data
);

   import sar_pkg::*;

   localparam int ROWS   = (SLOT_CAPACITY + ROW_W - 1) / ROW_W;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW     = ROW_AW + ROW_BITS;              // internal slot width
   localparam int CW     = $clog2(SLOT_CAPACITY + 1);      // counts
   localparam int STK_AW = $clog2(SLOT_CAPACITY);
   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

   sar_state_type      state_ff, state_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      depth_ff, depth_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [SW-1:0]      low_ff, low_in;
   logic [SW-1:0]      high_ff, high_in;
   sar_status_type     status_ff, status_in;
   logic [SW-1:0]      granted_ff, granted_in;
   logic [COUNT_W-1:0] limit_ff;
   logic [ROW_AW-1:0]  scan_addr_ff, scan_addr_in;
   logic [ROW_AW-1:0]  scan_row_ff, scan_row_in;
   logic               scan_pend_ff, scan_pend_in;
   logic               seen_ff, seen_in;

   logic [CW-1:0]      limit_eff;
   logic [CW-1:0]      depth_m1;
   logic               accept;

   // live map port
   logic               map_rd_en;
   logic [ROW_AW-1:0]  map_rd_addr;
   logic [ROW_W-1:0]   map_rd_data;
   logic               map_wr_en;
   logic [ROW_AW-1:0]  map_wr_addr;
   logic [ROW_W-1:0]   map_wr_data;

   // free stack port
   logic               stk_rd_en;
   logic [STK_AW-1:0]  stk_rd_addr;
   logic [SW-1:0]      stk_rd_data;
   logic               stk_wr_en;
   logic [STK_AW-1:0]  stk_wr_addr;

   sar_ram #(
      .DEPTH  (ROWS),
      .ADDR_W (ROW_AW),
      .DATA_W (ROW_W)
   ) u_live_map (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data)
   );

   sar_ram #(
      .DEPTH  (SLOT_CAPACITY),
      .ADDR_W (STK_AW),
      .DATA_W (SW)
   ) u_free_stack (
      .clock   (clock),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (slot_ff)
   );

   // Limit in force: register clamped to capacity
   assign limit_eff = (32'(limit_ff) > SLOT_CAPACITY) ? CW'(SLOT_CAPACITY) : CW'(limit_ff);
   assign depth_m1  = depth_ff - CW'(1);

   // Accepting is also allowed in the response cycle
   assign busy   = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      depth_in     = depth_ff;
      total_in     = total_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      scan_addr_in = scan_addr_ff;
      scan_row_in  = scan_row_ff;
      scan_pend_in = scan_pend_ff;
      seen_in      = seen_ff;

      map_rd_en    = 1'b0;
      map_rd_addr  = slot_ff[SW-1:ROW_BITS];
      map_wr_en    = 1'b0;
      map_wr_addr  = slot_ff[SW-1:ROW_BITS];
      map_wr_data  = map_rd_data;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = depth_m1[STK_AW-1:0];
      stk_wr_en    = 1'b0;
      stk_wr_addr  = depth_ff[STK_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = scan_addr_ff;
            map_wr_data = '0;
            if (scan_addr_ff == LAST_ROW) begin
               scan_addr_in = '0;
               state_in     = ST_IDLE;
            end else begin
               scan_addr_in = scan_addr_ff + ROW_AW'(1);
            end
         end

         ST_IDLE, ST_RESP: begin
            state_in = ST_IDLE;
            if (accept) begin
               status_in  = STATUS_OK;
               granted_in = '0;
               if (req_data.cmd == CMD_ALLOC) begin
                  if (total_ff >= limit_eff) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else if (depth_ff != '0) begin
                     stk_rd_en = 1'b1;
                     depth_in  = depth_m1;
                     state_in  = ST_POP;
                  end else begin
                     // fresh index is the live count
                     slot_in     = SW'(total_ff);
                     map_rd_en   = 1'b1;
                     map_rd_addr = slot_in[SW-1:ROW_BITS];
                     state_in    = ST_ALLOC_WR;
                  end
               end else begin
                  if (32'(req_data.slot_id) >= SLOT_CAPACITY) begin
                     status_in = STATUS_NOT_LIVE;
                     state_in  = ST_RESP;
                  end else begin
                     slot_in     = SW'(req_data.slot_id);
                     map_rd_en   = 1'b1;
                     map_rd_addr = slot_in[SW-1:ROW_BITS];
                     state_in    = ST_REL_CHK;
                  end
               end
            end
         end

         ST_POP: begin
            slot_in     = stk_rd_data;
            map_rd_en   = 1'b1;
            map_rd_addr = stk_rd_data[SW-1:ROW_BITS];
            state_in    = ST_ALLOC_WR;
         end

         ST_ALLOC_WR: begin
            map_wr_en   = 1'b1;
            map_wr_data = map_rd_data | (ROW_W'(1) << slot_ff[ROW_BITS-1:0]);
            total_in    = total_ff + CW'(1);
            granted_in  = slot_ff;
            if (total_ff == '0) begin
               low_in  = slot_ff;
               high_in = slot_ff;
            end else begin
               if (slot_ff < low_ff) begin
                  low_in = slot_ff;
               end
               if (slot_ff > high_ff) begin
                  high_in = slot_ff;
               end
            end
            state_in = ST_RESP;
         end

         ST_REL_CHK: begin
            if (!map_rd_data[slot_ff[ROW_BITS-1:0]]) begin
               status_in = STATUS_NOT_LIVE;
               state_in  = ST_RESP;
            end else begin
               map_wr_en   = 1'b1;
               map_wr_data = map_rd_data & ~(ROW_W'(1) << slot_ff[ROW_BITS-1:0]);
               if (depth_ff != CW'(SLOT_CAPACITY)) begin
                  stk_wr_en = 1'b1;
                  depth_in  = depth_ff + CW'(1);
               end
               total_in = total_ff - CW'(1);
               if (total_ff == CW'(1)) begin
                  low_in   = '0;
                  high_in  = '0;
                  state_in = ST_RESP;
               end else if (slot_ff == low_ff || slot_ff == high_ff) begin
                  // an end went away: rescan every row
                  scan_addr_in = '0;
                  scan_pend_in = 1'b0;
                  seen_in      = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_SCAN: begin
            map_rd_en    = 1'b1;
            map_rd_addr  = scan_addr_ff;
            scan_pend_in = 1'b1;
            scan_row_in  = scan_addr_ff;
            if (scan_addr_ff == LAST_ROW) begin
               scan_addr_in = '0;
               state_in     = ST_SCAN_END;
            end else begin
               scan_addr_in = scan_addr_ff + ROW_AW'(1);
            end
         end

         ST_SCAN_END: begin
            scan_pend_in = 1'b0;
            state_in     = ST_RESP;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Row read in the previous cycle during the rescan
      if ((state_ff == ST_SCAN || state_ff == ST_SCAN_END) && scan_pend_ff &&
          (map_rd_data != '0)) begin
         if (!seen_ff) begin
            low_in  = {scan_row_ff, lowest_set(map_rd_data)};
            seen_in = 1'b1;
         end
         high_in = {scan_row_ff, highest_set(map_rd_data)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         depth_ff     <= '0;
         total_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         scan_addr_ff <= '0;
         scan_pend_ff <= 1'b0;
         seen_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         total_ff     <= total_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         scan_addr_ff <= scan_addr_in;
         scan_pend_ff <= scan_pend_in;
         seen_ff      <= seen_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      scan_row_ff <= scan_row_in;
   end

   assign rsp_valid             = (state_ff == ST_RESP);
   assign rsp_data.status       = status_ff;
   assign rsp_data.granted_slot = SLOT_W'(granted_ff);
   assign rsp_data.live_count   = COUNT_W'(total_ff);
   assign rsp_data.first_live   = SLOT_W'(low_ff);
   assign rsp_data.last_live    = SLOT_W'(high_ff);

endmodule
